// File: rtl/core/nlcf_pkg.sv
package nlcf_pkg;

  localparam int unsigned TermsDefault = 9;

  localparam int unsigned NumW   = 40;
  localparam int unsigned DenW   = 44;
  localparam int unsigned NMagW  = 34;
  localparam int unsigned DMagW  = 43;
  localparam int unsigned QuotW  = 41;
  localparam int unsigned QSgnW  = 42;
  localparam int unsigned SumW   = 46;
  localparam int unsigned LowBits = 11;

  localparam logic signed [DenW-1:0] OneQ30      = 44'sd1073741824;
  localparam logic signed [SumW-1:0] Ln2Q30      = 46'sd744261118;
  localparam logic        [31:0]     Sqrt2Q31    = 32'hB504F333;
  localparam logic        [NMagW-1:0] NumClamp   = {NMagW{1'b1}};
  localparam logic        [QuotW-1:0] QuotLimit  = {1'b1, {(QuotW-1){1'b0}}};

  typedef struct packed {
    logic               err;
    logic signed [5:0]  k;
    logic signed [31:0] u;
  } ctx_t;

  typedef struct packed {
    logic              vld;
    logic              neg;
    logic              sat;
    logic              dz;
    logic [DMagW-1:0]  d;
    logic [DMagW-1:0]  r;
    logic [QuotW-1:0]  bits;
    logic [QuotW-1:0]  q;
    ctx_t              ctx;
  } cell_t;

endpackage

// File: rtl/core/nlcf_if.sv
interface nlcf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_value;

  modport source (output valid, output x_value, input ready);
  modport sink (input valid, input x_value, output ready);
endinterface

interface nlcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ln_value;
  logic               domain_error;

  modport source (output valid, output ln_value, output domain_error, input ready);
  modport sink (input valid, input ln_value, input domain_error, output ready);
endinterface

// File: rtl/core/natural_log_continued_fraction.sv
// natural log of an unsigned q16.16 operand, result signed q8.24
// in_i carries x_value; out_o carries ln_value and domain_error
// a word moves on a channel at a clock edge with valid and ready high
// a zero operand gives domain_error 1 and ln_value 0
// the operand is normalized, then each continued fraction level runs two
// dividers and a last divider forms u/(1+s); every divider is a chain of
// 41 restoring cells, one quotient bit per cell, plus an entry and an exit register
// throughput: one word per cycle while out_o does not stall; every stage then moves in every cycle
// a stall on out_o holds the whole pipeline and drops in_i.ready; the
// finished word stays in the output register until taken
// reset clears the valid bits only; the pipeline then accepts at once
module natural_log_continued_fraction #(
  parameter int unsigned TERMS = nlcf_pkg::TermsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  nlcf_in_if.sink           in_i,
  nlcf_out_if.source        out_o
);

  localparam int unsigned NW = nlcf_pkg::NumW;
  localparam int unsigned DW = nlcf_pkg::DenW;
  localparam int unsigned QW = nlcf_pkg::QSgnW;

  logic                      en;
  logic                      out_vld_q;
  logic signed [31:0]        out_ln_q;
  logic                      out_err_q;

  logic                      lv_vld [TERMS+1];
  logic signed [QW-1:0]      lv_s   [TERMS+1];
  nlcf_pkg::ctx_t            lv_ctx [TERMS+1];

  logic                      fin_vld;
  logic signed [QW-1:0]      fin_q;
  nlcf_pkg::ctx_t            fin_ctx;

  logic signed [nlcf_pkg::SumW-1:0] total;
  logic [nlcf_pkg::SumW-1:0]        mag;
  logic [nlcf_pkg::SumW-1:0]        res;

  assign en        = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  nlcf_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_i.valid),
    .x_i    (in_i.x_value),
    .vld_o  (lv_vld[0]),
    .ctx_o  (lv_ctx[0])
  );

  assign lv_s[0] = '0;

  for (genvar g = 0; g < TERMS; g++) begin : g_level
    localparam logic signed [NW-1:0] IVal = NW'(TERMS - g);
    localparam logic signed [DW-1:0] DIn  = DW'(2 * (TERMS - g) + 1) <<< 30;

    logic signed [NW-1:0] t_a, t_b;
    logic signed [DW-1:0] den_a, den_b;
    logic                 mid_vld;
    logic signed [QW-1:0] mid_q;
    nlcf_pkg::ctx_t       mid_ctx;

    assign t_a   = $signed({{(NW-32){lv_ctx[g].u[31]}}, lv_ctx[g].u}) * IVal;
    assign den_a = DIn + $signed({{(DW-QW){lv_s[g][QW-1]}}, lv_s[g]});

    nlcf_div u_div_inner (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (lv_vld[g]),
      .num_i  (t_a),
      .den_i  (den_a),
      .ctx_i  (lv_ctx[g]),
      .vld_o  (mid_vld),
      .q_o    (mid_q),
      .ctx_o  (mid_ctx)
    );

    assign t_b   = $signed({{(NW-32){mid_ctx.u[31]}}, mid_ctx.u}) * IVal;
    assign den_b = (nlcf_pkg::OneQ30 <<< 1) + $signed({{(DW-QW){mid_q[QW-1]}}, mid_q});

    nlcf_div u_div_outer (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (mid_vld),
      .num_i  (t_b),
      .den_i  (den_b),
      .ctx_i  (mid_ctx),
      .vld_o  (lv_vld[g+1]),
      .q_o    (lv_s[g+1]),
      .ctx_o  (lv_ctx[g+1])
    );
  end

  nlcf_div u_div_final (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (lv_vld[TERMS]),
    .num_i  ($signed({{(NW-32){lv_ctx[TERMS].u[31]}}, lv_ctx[TERMS].u})),
    .den_i  (nlcf_pkg::OneQ30 +
             $signed({{(DW-QW){lv_s[TERMS][QW-1]}}, lv_s[TERMS]})),
    .ctx_i  (lv_ctx[TERMS]),
    .vld_o  (fin_vld),
    .q_o    (fin_q),
    .ctx_o  (fin_ctx)
  );

  always_comb begin
    total = $signed({{(nlcf_pkg::SumW-6){fin_ctx.k[5]}}, fin_ctx.k}) * nlcf_pkg::Ln2Q30
          + $signed({{(nlcf_pkg::SumW-QW){fin_q[QW-1]}}, fin_q});
    mag   = total[nlcf_pkg::SumW-1] ? (~total + 1'b1) : total;
    mag   = mag >> 6;
    res   = total[nlcf_pkg::SumW-1] ? (~mag + 1'b1) : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= fin_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_err_q <= fin_ctx.err;
      out_ln_q  <= fin_ctx.err ? 32'sd0 : $signed(res[31:0]);
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.ln_value     = out_ln_q;
  assign out_o.domain_error = out_err_q;

endmodule

// File: rtl/core/nlcf_norm.sv
module nlcf_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [31:0]         x_i,
  output logic                vld_o,
  output nlcf_pkg::ctx_t      ctx_o
);

  logic           vld_q;
  nlcf_pkg::ctx_t ctx_q, ctx_d;
  logic [4:0]     p;
  logic [31:0]    m;
  logic [32:0]    u_w;

  always_comb begin
    p = 5'd0;
    for (int j = 0; j < 32; j++) begin
      if (x_i[j]) begin
        p = 5'(j);
      end
    end
    m = x_i << (5'd31 - p);
    ctx_d.err = (x_i == 32'd0);
    if (m > nlcf_pkg::Sqrt2Q31) begin
      ctx_d.k = $signed({1'b0, p}) - 6'sd15;
      u_w     = {3'b000, m[31:2]} - 33'd1073741824;
    end else begin
      ctx_d.k = $signed({1'b0, p}) - 6'sd16;
      u_w     = {2'b00, m[31:1]} - 33'd1073741824;
    end
    ctx_d.u = $signed(u_w[31:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q <= ctx_d;
    end
  end

  assign vld_o = vld_q;
  assign ctx_o = ctx_q;

endmodule

// File: rtl/core/nlcf_div_cell.sv
module nlcf_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  nlcf_pkg::cell_t   a_i,
  output nlcf_pkg::cell_t   b_o
);

  nlcf_pkg::cell_t            b_q, b_d;
  logic [nlcf_pkg::DMagW:0]   rr;
  logic [nlcf_pkg::DMagW:0]   diff;

  always_comb begin
    b_d  = a_i;
    rr   = {a_i.r, a_i.bits[nlcf_pkg::QuotW-1]};
    diff = rr - {1'b0, a_i.d};
    b_d.bits = {a_i.bits[nlcf_pkg::QuotW-2:0], 1'b0};
    if (rr >= {1'b0, a_i.d}) begin
      b_d.r = diff[nlcf_pkg::DMagW-1:0];
      b_d.q = {a_i.q[nlcf_pkg::QuotW-2:0], 1'b1};
    end else begin
      b_d.r = rr[nlcf_pkg::DMagW-1:0];
      b_d.q = {a_i.q[nlcf_pkg::QuotW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q.vld <= 1'b0;
    end else if (en_i) begin
      b_q <= b_d;
    end
  end

  assign b_o = b_q;

endmodule

// File: rtl/core/nlcf_div.sv
module nlcf_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  vld_i,
  input  logic signed [nlcf_pkg::NumW-1:0]      num_i,
  input  logic signed [nlcf_pkg::DenW-1:0]      den_i,
  input  nlcf_pkg::ctx_t                        ctx_i,
  output logic                                  vld_o,
  output logic signed [nlcf_pkg::QSgnW-1:0]     q_o,
  output nlcf_pkg::ctx_t                        ctx_o
);

  localparam int unsigned NC = nlcf_pkg::QuotW;

  nlcf_pkg::cell_t                 prep_d, prep_q;
  nlcf_pkg::cell_t                 chain [NC+1];
  logic [nlcf_pkg::NumW-1:0]       nmag;
  logic [nlcf_pkg::DenW-1:0]       dmag;
  logic [nlcf_pkg::NMagW-1:0]      n;
  logic [nlcf_pkg::QuotW-1:0]      qc;
  logic [nlcf_pkg::QSgnW-1:0]      qs;
  logic                            vld_q;
  logic signed [nlcf_pkg::QSgnW-1:0] q_q;
  nlcf_pkg::ctx_t                  ctx_q;

  always_comb begin
    nmag = num_i[nlcf_pkg::NumW-1] ? (~num_i + 1'b1) : num_i;
    dmag = den_i[nlcf_pkg::DenW-1] ? (~den_i + 1'b1) : den_i;
    if (nmag > nlcf_pkg::NumW'(nlcf_pkg::NumClamp)) begin
      n = nlcf_pkg::NumClamp;
    end else begin
      n = nmag[nlcf_pkg::NMagW-1:0];
    end
    prep_d.vld  = vld_i;
    prep_d.neg  = num_i[nlcf_pkg::NumW-1] ^ den_i[nlcf_pkg::DenW-1];
    prep_d.d    = dmag[nlcf_pkg::DMagW-1:0];
    prep_d.dz   = (dmag == '0);
    prep_d.sat  = (nlcf_pkg::DMagW'(n[nlcf_pkg::NMagW-1:nlcf_pkg::LowBits]) >=
                   dmag[nlcf_pkg::DMagW-1:0]);
    prep_d.r    = nlcf_pkg::DMagW'(n[nlcf_pkg::NMagW-1:nlcf_pkg::LowBits]);
    prep_d.bits = {n[nlcf_pkg::LowBits-1:0], 30'd0};
    prep_d.q    = '0;
    prep_d.ctx  = ctx_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_q.vld <= 1'b0;
    end else if (en_i) begin
      prep_q <= prep_d;
    end
  end

  assign chain[0] = prep_q;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    nlcf_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .a_i    (chain[g]),
      .b_o    (chain[g+1])
    );
  end

  always_comb begin
    if (chain[NC].sat || (chain[NC].q > nlcf_pkg::QuotLimit)) begin
      qc = nlcf_pkg::QuotLimit;
    end else begin
      qc = chain[NC].q;
    end
    if (chain[NC].dz) begin
      qc = '0;
    end
    qs = {1'b0, qc};
    if (chain[NC].neg) begin
      qs = ~qs + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= chain[NC].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q   <= $signed(qs);
      ctx_q <= chain[NC].ctx;
    end
  end

  assign vld_o = vld_q;
  assign q_o   = q_q;
  assign ctx_o = ctx_q;

endmodule

// File: dv/tb_natural_log_continued_fraction.sv
module tb_natural_log_continued_fraction;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom = 1850;
  localparam int unsigned Latency = 2 + 43 * (2 * nlcf_pkg::TermsDefault + 1);
  localparam int unsigned IdleLimit = 4 * Latency + 200;

  typedef struct {
    logic [31:0] x;
    logic        known;
    logic [31:0] ln;
    logic        err;
  } dir_row_t;

  typedef struct {
    logic [31:0] ln;
    logic        err;
  } log_word_t;

  logic clk_i;
  logic rst_ni;

  nlcf_in_if  in_if ();
  nlcf_out_if out_if ();

  natural_log_continued_fraction dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  log_word_t expected_logs[$];
  int unsigned n_fail;
  int unsigned idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned mag_of(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint q30_div(longint num, longint den);
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    n = mag_of(num);
    d = mag_of(den);
    if (d == 0) return 0;
    if (n >= (64'd1 << 34)) n = (64'd1 << 34) - 1;
    q = (n << 30) / d;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic log_word_t predict_log(logic [31:0] x);
    log_word_t r;
    int p;
    int k;
    longint unsigned m;
    longint u;
    longint s;
    longint t;
    longint inner;
    longint total;
    longint unsigned mg;
    if (x == 0) begin
      r.ln = '0;
      r.err = 1'b1;
      return r;
    end
    p = 31;
    while (p > 0 && x[p] == 1'b0) p--;
    m = (64'(x) << (31 - p)) & 64'hFFFF_FFFF;
    if (m > 64'(nlcf_pkg::Sqrt2Q31)) begin
      k = p - 15;
      u = longint'(m >> 2) - 64'sd1073741824;
    end else begin
      k = p - 16;
      u = longint'(m >> 1) - 64'sd1073741824;
    end
    s = 0;
    for (int i = nlcf_pkg::TermsDefault; i >= 1; i--) begin
      t = longint'(i) * u;
      inner = q30_div(t, longint'(2 * i + 1) * 64'sd1073741824 + s);
      s = q30_div(t, 64'sd2147483648 + inner);
    end
    total = longint'(k) * 64'sd744261118 + q30_div(u, 64'sd1073741824 + s);
    mg = mag_of(total) >> 6;
    r.ln = total < 0 ? 32'(-longint'(mg)) : 32'(mg);
    r.err = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    int unsigned sel;
    int unsigned w;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom();
    if (sel == 1) return $urandom_range(0, 3);
    w = $urandom_range(1, 32);
    return $urandom() >> (32 - w);
  endfunction

  dir_row_t dir_rows[] = '{
    '{32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
    '{32'h0001_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{32'h0000_0001, 1'b0, 32'h0, 1'b0},
    '{32'h0000_0002, 1'b0, 32'h0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{32'h0002_0000, 1'b0, 32'h0, 1'b0},
    '{32'h0000_8000, 1'b0, 32'h0, 1'b0},
    '{32'h0001_6A09, 1'b0, 32'h0, 1'b0},
    '{32'h0001_6A0A, 1'b0, 32'h0, 1'b0},
    '{32'hB504_F333, 1'b0, 32'h0, 1'b0},
    '{32'hB504_F334, 1'b0, 32'h0, 1'b0},
    '{32'h0002_B7E1, 1'b0, 32'h0, 1'b0},
    '{32'h5555_5555, 1'b0, 32'h0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 32'h0, 1'b0},
    '{32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
    '{32'h0000_FFFF, 1'b0, 32'h0, 1'b0},
    '{32'h0001_0001, 1'b0, 32'h0, 1'b0}
  };

  task automatic send_word(logic [31:0] x, log_word_t exp_word);
    int unsigned idle;
    idle = $urandom_range(0, 6);
    if (idle != 0) begin
      in_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.x_value <= x;
    do @(posedge clk_i); while (!in_if.ready);
    expected_logs.push_back(exp_word);
  endtask

  initial begin
    log_word_t w;
    in_if.valid    = 1'b0;
    in_if.x_value  = '0;
    out_if.ready   = 1'b0;
    n_fail         = 0;
    rst_ni         = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) begin
        w.ln = dir_rows[i].ln;
        w.err = dir_rows[i].err;
      end else begin
        w = predict_log(dir_rows[i].x);
      end
      send_word(dir_rows[i].x, w);
    end
    for (int n = 0; n < NumRandom; n++) begin
      logic [31:0] x;
      x = rand_operand();
      send_word(x, predict_log(x));
    end
    in_if.valid <= 1'b0;
    while (expected_logs.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver with random stalls and bursts of steady ready
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  always @(posedge clk_i) begin
    log_word_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_logs.size() == 0) begin
        $error("unexpected word ln_value %h domain_error %b",
               out_if.ln_value, out_if.domain_error);
        n_fail++;
      end else begin
        e = expected_logs.pop_front();
        if (out_if.ln_value !== e.ln) begin
          $error("ln_value expected %h actual %h", e.ln, out_if.ln_value);
          n_fail++;
        end
        if (out_if.domain_error !== e.err) begin
          $error("domain_error expected %b actual %b", e.err, out_if.domain_error);
          n_fail++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
